// ===== src/general_purpose_timer_macros.svh =====
// assertion macros shared by the timer checker
// no dependencies; pulled in by the checker file
`ifndef GENERAL_PURPOSE_TIMER_MACROS_SVH
`define GENERAL_PURPOSE_TIMER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gpt_pkg.sv =====
// shared types, register map and codes of the general purpose timer
// no dependencies; imported by gpt_core and general_purpose_timer
`default_nettype none

package gpt_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int MAX_CHANNELS     = 4;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2
    } gpt_func_t;

    // register word indexes
    localparam logic [4:0] REG_CR    = 5'd0;
    localparam logic [4:0] REG_DIER  = 5'd3;
    localparam logic [4:0] REG_SR    = 5'd4;
    localparam logic [4:0] REG_EGR   = 5'd5;
    localparam logic [4:0] REG_CCMR1 = 5'd6;
    localparam logic [4:0] REG_CCMR2 = 5'd7;
    localparam logic [4:0] REG_CCER  = 5'd8;
    localparam logic [4:0] REG_CNT   = 5'd9;
    localparam logic [4:0] REG_PSC   = 5'd10;
    localparam logic [4:0] REG_ARR   = 5'd11;
    localparam logic [4:0] REG_CCR1  = 5'd13;
    localparam logic [4:0] REG_CCR2  = 5'd14;
    localparam logic [4:0] REG_CCR3  = 5'd15;
    localparam logic [4:0] REG_CCR4  = 5'd16;

    // control register bits
    localparam int         CTL_EN_BIT   = 0;
    localparam int         CTL_OPM_BIT  = 3;
    localparam int         CTL_DOWN_BIT = 4;
    localparam logic [4:0] CTL_MASK     = 5'b11001;

    // output compare modes, bits 6:4 of a channel byte
    localparam logic [2:0] MODE_SET    = 3'd1;
    localparam logic [2:0] MODE_CLEAR  = 3'd2;
    localparam logic [2:0] MODE_TOGGLE = 3'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  reg_index;
        logic [15:0] write_data;
    } gpt_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq;
        logic [3:0]  channel_outputs;
        logic        update_event;
    } gpt_result_t;

endpackage

`default_nettype wire

// ===== src/gpt_core.sv =====
// timer state and the per-item update: ticks, register writes and reads
// depends on gpt_pkg
`default_nettype none

module gpt_core
    import gpt_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  gpt_item_t   item,
    output gpt_result_t result
);

    logic [4:0]              ctl_reg, ctl_next;
    logic                    dier_reg, dier_next;
    logic [4:0]              sr_reg, sr_next;
    logic [15:0]             ccmr_reg [2];
    logic [15:0]             ccmr_next [2];
    logic [15:0]             ccer_reg, ccer_next;
    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic [15:0]             psc_reg, psc_next;
    logic [15:0]             psc_act_reg, psc_act_next;
    logic [15:0]             psc_cnt_reg, psc_cnt_next;
    logic [COUNTER_BITS-1:0] arr_reg, arr_next;
    logic [COUNTER_BITS-1:0] ccr_reg [MAX_CHANNELS];
    logic [COUNTER_BITS-1:0] ccr_next [MAX_CHANNELS];
    logic [3:0]              lvl_reg, lvl_next;

    logic [COUNTER_BITS-1:0] wr_cnt;
    logic [1:0]              ccr_sel;
    logic [15:0]             rd;
    logic                    upd;
    logic [3:0]              pins;

    assign wr_cnt  = COUNTER_BITS'(item.write_data);
    assign ccr_sel = 2'(item.reg_index - REG_CCR1);

    always_comb
    begin
        logic [2:0] mode;
        ctl_next     = ctl_reg;
        dier_next    = dier_reg;
        sr_next      = sr_reg;
        ccmr_next    = ccmr_reg;
        ccer_next    = ccer_reg;
        cnt_next     = cnt_reg;
        psc_next     = psc_reg;
        psc_act_next = psc_act_reg;
        psc_cnt_next = psc_cnt_reg;
        arr_next     = arr_reg;
        ccr_next     = ccr_reg;
        lvl_next     = lvl_reg;
        rd           = '0;
        upd          = 1'b0;
        mode         = '0;

        if (step)
        begin
            unique case (gpt_func_t'(item.func))
                FUNC_TICK:
                begin
                    if (ctl_reg[CTL_EN_BIT])
                    begin
                        if (psc_cnt_reg < psc_act_reg)
                        begin
                            psc_cnt_next = 16'(psc_cnt_reg + 16'd1);
                        end
                        else
                        begin
                            psc_cnt_next = '0;
                            if (ctl_reg[CTL_DOWN_BIT])
                            begin
                                if (cnt_reg == '0)
                                begin
                                    cnt_next = arr_reg;
                                    upd      = 1'b1;
                                end
                                else
                                begin
                                    cnt_next = COUNTER_BITS'(cnt_reg - 1'b1);
                                end
                            end
                            else
                            begin
                                // a counter above reload also wraps
                                if (cnt_reg >= arr_reg)
                                begin
                                    cnt_next = '0;
                                    upd      = 1'b1;
                                end
                                else
                                begin
                                    cnt_next = COUNTER_BITS'(cnt_reg + 1'b1);
                                end
                            end
                            if (upd)
                            begin
                                sr_next[0]   = 1'b1;
                                psc_act_next = psc_reg;
                                if (ctl_reg[CTL_OPM_BIT])
                                begin
                                    ctl_next[CTL_EN_BIT] = 1'b0;
                                end
                            end
                            for (int c = 0; c < NUM_CHANNELS; c++)
                            begin
                                if (cnt_next == ccr_reg[2'(c)])
                                begin
                                    sr_next[c+1] = 1'b1;
                                    mode = ccmr_reg[1'(c >> 1)][(c & 1) * 8 + 4 +: 3];
                                    case (mode)
                                        MODE_SET:    lvl_next[c] = 1'b1;
                                        MODE_CLEAR:  lvl_next[c] = 1'b0;
                                        MODE_TOGGLE: lvl_next[c] = ~lvl_reg[c];
                                        default:     lvl_next[c] = lvl_reg[c];
                                    endcase
                                end
                            end
                        end
                    end
                end
                FUNC_WRITE:
                begin
                    unique case (item.reg_index)
                        REG_CR:    ctl_next  = item.write_data[4:0] & CTL_MASK;
                        REG_DIER:  dier_next = item.write_data[0];
                        // status bits are cleared by writing zero
                        REG_SR:    sr_next   = sr_reg & item.write_data[4:0];
                        REG_EGR:
                        begin
                            if (item.write_data[0])
                            begin
                                cnt_next     = ctl_reg[CTL_DOWN_BIT] ? arr_reg : '0;
                                psc_cnt_next = '0;
                                sr_next[0]   = 1'b1;
                                psc_act_next = psc_reg;
                                upd          = 1'b1;
                            end
                            sr_next[4:1] = sr_next[4:1] | item.write_data[4:1];
                        end
                        REG_CCMR1: ccmr_next[0] = item.write_data;
                        REG_CCMR2: ccmr_next[1] = item.write_data;
                        REG_CCER:  ccer_next    = item.write_data;
                        REG_CNT:   cnt_next     = wr_cnt;
                        REG_PSC:   psc_next     = item.write_data;
                        REG_ARR:   arr_next     = wr_cnt;
                        REG_CCR1, REG_CCR2, REG_CCR3, REG_CCR4:
                            ccr_next[ccr_sel] = wr_cnt;
                        default: ;
                    endcase
                end
                FUNC_READ:
                begin
                    unique case (item.reg_index)
                        REG_CR:    rd = 16'(ctl_reg);
                        REG_DIER:  rd = 16'(dier_reg);
                        REG_SR:    rd = 16'(sr_reg);
                        REG_CCMR1: rd = ccmr_reg[0];
                        REG_CCMR2: rd = ccmr_reg[1];
                        REG_CCER:  rd = ccer_reg;
                        REG_CNT:   rd = 16'(cnt_reg);
                        REG_PSC:   rd = psc_reg;
                        REG_ARR:   rd = 16'(arr_reg);
                        REG_CCR1, REG_CCR2, REG_CCR3, REG_CCR4:
                            rd = 16'(ccr_reg[ccr_sel]);
                        default:   rd = '0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // pins follow the state as it stands after this item
    always_comb
    begin
        pins = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (ccer_next[4*c])
            begin
                pins[c] = lvl_next[c] ^ ccer_next[4*c+1];
            end
        end
    end

    assign result.read_data       = rd;
    assign result.irq             = sr_next[0] & dier_next;
    assign result.channel_outputs = pins;
    assign result.update_event    = upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg     <= '0;
            dier_reg    <= 1'b0;
            sr_reg      <= '0;
            ccmr_reg[0] <= '0;
            ccmr_reg[1] <= '0;
            ccer_reg    <= '0;
            cnt_reg     <= '0;
            psc_reg     <= '0;
            psc_act_reg <= '0;
            psc_cnt_reg <= '0;
            arr_reg     <= '1;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                ccr_reg[i] <= '0;
            end
            lvl_reg     <= '0;
        end
        else
        begin
            ctl_reg     <= ctl_next;
            dier_reg    <= dier_next;
            sr_reg      <= sr_next;
            ccmr_reg    <= ccmr_next;
            ccer_reg    <= ccer_next;
            cnt_reg     <= cnt_next;
            psc_reg     <= psc_next;
            psc_act_reg <= psc_act_next;
            psc_cnt_reg <= psc_cnt_next;
            arr_reg     <= arr_next;
            ccr_reg     <= ccr_next;
            lvl_reg     <= lvl_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/general_purpose_timer.sv =====
// general purpose timer with prescaler, auto-reload and compare channels
//
// one input transfer is one item: a clock tick, a register write or a
// register read, selected by s_tuser. every item gives exactly one result
// transfer on the master side with the read data, the update interrupt
// request, the compare output pins and an update-event flag.
// an accepted item is processed by the core while it sits in the input
// register; the result register loads from the core when the item leaves
// the input register, and m_tvalid is set with it. while m_tready is high,
// one item per cycle is sustained: the timer state update is a single pass
// of short logic between the two registers.
// when m_tready is low the result register holds; the input register still
// takes one more item, then s_tready drops until the result is taken.
// reset empties both pipeline stages and puts every timer register to
// zero, except reload which comes up all ones.
// depends on gpt_pkg and gpt_core
`default_nettype none

module general_purpose_timer
    import gpt_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // reg_index[4:0], write_data[20:5], zero[23:21]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // read_data[15:0], irq[16], channel_outputs[20:17],
                                   // update_event[21], zero[23:22]
);

    logic        in_valid_reg;
    gpt_item_t   in_item_reg;
    logic        out_valid_reg;
    gpt_result_t out_res_reg;

    logic        advance;
    gpt_result_t core_res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    gpt_core #(
        .COUNTER_BITS (COUNTER_BITS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.func       <= s_tuser;
            in_item_reg.reg_index  <= s_tdata[4:0];
            in_item_reg.write_data <= s_tdata[20:5];
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.update_event, out_res_reg.channel_outputs,
                       out_res_reg.irq, out_res_reg.read_data};

endmodule

`default_nettype wire

// ===== src/gpt_checker.sv =====
// port-level checks of the timer stream channels, bound to the top level
// depends on general_purpose_timer_macros.svh
`default_nettype none
`include "general_purpose_timer_macros.svh"

module gpt_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    logic out_stall;
    logic in_xfer;

    assign out_stall = m_tvalid && !m_tready;
    assign in_xfer   = s_tvalid && s_tready;

    // stalled result holds
    `GPT_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

    // the slave side only backs up behind a stalled master side
    `GPT_ASSERT_NOW(a_backpressure, !s_tready, out_stall, "input stall without output stall")

    // a fresh result must follow an input transfer
    `GPT_ASSERT_NOW(a_latency, m_tvalid && !$past(m_tvalid), $past(in_xfer, 2), "orphan result")

    // padding bits of the result stay zero
    `GPT_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[23:22] == 2'b00, "result padding not zero")

endmodule

bind general_purpose_timer gpt_checker u_gpt_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for general_purpose_timer: ticks, register writes and reads
// go in through the slave stream, every result is checked against a shadow model
// depends on gpt_pkg and the general_purpose_timer rtl
`timescale 1ns / 1ps

module testbench;
    import gpt_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [4:0] REG_GAP     = 5'd12;
    localparam logic [4:0] REG_TOP     = 5'd19;
    localparam int         RANDOM_ITEMS = 1400;
    localparam int         CYCLE_LIMIT  = 100000;

    // shadow copy of the timer registers, predicts one result per item
    class timer_shadow;
        bit [4:0]    ctrl;
        bit          irq_enable;
        bit [4:0]    flags;
        bit [15:0]   modes [2];
        bit [15:0]   out_en;
        bit [15:0]   count;
        bit [15:0]   psc_buf;
        bit [15:0]   psc_live;
        bit [15:0]   psc_count;
        bit [15:0]   reload;
        bit [15:0]   cmp [4];
        bit [3:0]    levels;
        gpt_result_t pending_results [$];
        int          mismatches;
        int          ticks;
        int          writes;
        int          reads;
        int          others;
        int          updates;

        function new();
            reload = 16'hffff;
        endfunction

        function void take_update();
            flags[0] = 1'b1;
            psc_live = psc_buf;
            if (ctrl[CTL_OPM_BIT])
                ctrl[CTL_EN_BIT] = 1'b0;
        endfunction

        function void match_compares();
            bit [2:0] mode;
            for (int c = 0; c < NUM_CHANNELS_DEF; c++)
            begin
                if (count == cmp[2'(c)])
                begin
                    flags[c + 1] = 1'b1;
                    mode = modes[1'(c / 2)][(c % 2) * 8 + 4 +: 3];
                    case (mode)
                        MODE_SET:    levels[c] = 1'b1;
                        MODE_CLEAR:  levels[c] = 1'b0;
                        MODE_TOGGLE: levels[c] = ~levels[c];
                        default:     ;
                    endcase
                end
            end
        endfunction

        function bit tick_counter();
            bit wrapped;
            wrapped = 1'b0;
            if (!ctrl[CTL_EN_BIT])
                return 1'b0;
            if (psc_count < psc_live)
            begin
                psc_count++;
                return 1'b0;
            end
            psc_count = '0;
            if (ctrl[CTL_DOWN_BIT])
            begin
                if (count == 16'd0)
                begin
                    count = reload;
                    wrapped = 1'b1;
                end
                else
                    count--;
            end
            else if (count >= reload)
            begin
                // also covers a counter written above reload
                count = '0;
                wrapped = 1'b1;
            end
            else
                count++;
            if (wrapped)
                take_update();
            match_compares();
            return wrapped;
        endfunction

        function bit write_register(logic [4:0] idx, logic [15:0] d);
            bit forced;
            forced = 1'b0;
            case (idx)
                REG_CR:    ctrl = d[4:0] & CTL_MASK;
                REG_DIER:  irq_enable = d[0];
                REG_SR:    flags = flags & d[4:0];
                REG_EGR:
                begin
                    // forced update never stops the timer in one-pulse mode
                    if (d[0])
                    begin
                        count = ctrl[CTL_DOWN_BIT] ? reload : 16'd0;
                        psc_count = '0;
                        flags[0] = 1'b1;
                        psc_live = psc_buf;
                        forced = 1'b1;
                    end
                    flags = flags | {d[4:1], 1'b0};
                end
                REG_CCMR1: modes[0] = d;
                REG_CCMR2: modes[1] = d;
                REG_CCER:  out_en = d;
                REG_CNT:   count = d;
                REG_PSC:   psc_buf = d;
                REG_ARR:   reload = d;
                REG_CCR1, REG_CCR2, REG_CCR3, REG_CCR4: cmp[2'(idx - REG_CCR1)] = d;
                default:   ;
            endcase
            return forced;
        endfunction

        function logic [15:0] read_register(logic [4:0] idx);
            case (idx)
                REG_CR:    return {11'd0, ctrl};
                REG_DIER:  return {15'd0, irq_enable};
                REG_SR:    return {11'd0, flags};
                REG_CCMR1: return modes[0];
                REG_CCMR2: return modes[1];
                REG_CCER:  return out_en;
                REG_CNT:   return count;
                REG_PSC:   return psc_buf;
                REG_ARR:   return reload;
                REG_CCR1, REG_CCR2, REG_CCR3, REG_CCR4: return cmp[2'(idx - REG_CCR1)];
                default:   return 16'd0;
            endcase
        endfunction

        function void note_item(logic [1:0] func, logic [4:0] idx, logic [15:0] d);
            gpt_result_t r;
            r = '0;
            case (func)
                FUNC_TICK:
                begin
                    ticks++;
                    r.update_event = tick_counter();
                end
                FUNC_WRITE:
                begin
                    writes++;
                    r.update_event = write_register(idx, d);
                end
                FUNC_READ:
                begin
                    reads++;
                    r.read_data = read_register(idx);
                end
                default: others++;
            endcase
            updates += r.update_event;
            r.irq = flags[0] & irq_enable;
            for (int c = 0; c < NUM_CHANNELS_DEF; c++)
                if (out_en[4 * c])
                    r.channel_outputs[c] = levels[c] ^ out_en[4 * c + 1];
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(gpt_result_t got);
            gpt_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing pending", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data != want.read_data)
                report_mismatch($sformatf("read_data %h, want %h", got.read_data,
                                          want.read_data));
            if (got.irq != want.irq)
                report_mismatch($sformatf("irq %b, want %b", got.irq, want.irq));
            if (got.channel_outputs != want.channel_outputs)
                report_mismatch($sformatf("channel_outputs %b, want %b",
                                          got.channel_outputs, want.channel_outputs));
            if (got.update_event != want.update_event)
                report_mismatch($sformatf("update_event %b, want %b", got.update_event,
                                          want.update_event));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // reg_index[4:0], write_data[20:5], zero[23:21]
    logic [1:0]  s_tuser;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // read_data[15:0], irq[16], channel_outputs[20:17],
                            // update_event[21], zero[23:22]

    timer_shadow shadow;
    bit          steady_flow;
    int          cycle_count = 0;
    logic [4:0]  mapped_regs [14];

    general_purpose_timer i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
        m_tready <= steady_flow || ($urandom_range(0, 99) >= 26);

    always @(posedge clk)
    begin : watch_bus
        gpt_result_t seen;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                shadow.note_item(s_tuser, s_tdata[4:0], s_tdata[20:5]);
            if (m_tvalid && m_tready)
            begin
                seen.read_data       = m_tdata[15:0];
                seen.irq             = m_tdata[16];
                seen.channel_outputs = m_tdata[20:17];
                seen.update_event    = m_tdata[21];
                shadow.check_result(seen);
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    // holds the item until its transfer, then maybe leaves a gap
    task automatic push_item(input logic [1:0] func, input logic [4:0] idx,
                             input logic [15:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {3'b000, data, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!steady_flow && $urandom_range(0, 99) < 17)
        begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [1:0]  func;
        logic [4:0]  idx;
        logic [15:0] data;
        int          pick;

        shadow = new();
        mapped_regs = '{REG_CR, REG_DIER, REG_SR, REG_EGR, REG_CCMR1, REG_CCMR2, REG_CCER,
                        REG_CNT, REG_PSC, REG_ARR, REG_CCR1, REG_CCR2, REG_CCR3, REG_CCR4};
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        steady_flow = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset values, unused index and unused func
        push_item(FUNC_READ,   REG_ARR, 16'h0000);
        push_item(FUNC_READ,   REG_TOP, 16'h0000);
        push_item(FUNC_WRITE,  REG_GAP, 16'hffff);
        push_item(FUNC_READ,   REG_GAP, 16'h0000);
        push_item(FUNC_UNUSED, REG_CR,  16'hffff);
        // short up-count with set, toggle, clear and inert modes
        push_item(FUNC_WRITE,  REG_ARR,   16'd3);
        push_item(FUNC_WRITE,  REG_CCMR1, 16'h3010);
        push_item(FUNC_WRITE,  REG_CCMR2, 16'h7020);
        push_item(FUNC_WRITE,  REG_CCER,  16'h3131);
        push_item(FUNC_WRITE,  REG_CCR1,  16'd1);
        push_item(FUNC_WRITE,  REG_CCR2,  16'd2);
        push_item(FUNC_WRITE,  REG_CCR4,  16'd3);
        push_item(FUNC_WRITE,  REG_CNT,   16'hffff);
        // reserved control bits are dropped
        push_item(FUNC_WRITE,  REG_CR,    16'hffe1);
        repeat (5) push_item(FUNC_TICK, REG_CR, 16'h0000);
        push_item(FUNC_WRITE,  REG_DIER,  16'hffff);
        push_item(FUNC_READ,   REG_SR,    16'h0000);
        push_item(FUNC_WRITE,  REG_SR,    16'hfffe);
        push_item(FUNC_WRITE,  REG_EGR,   16'hffff);
        // one-pulse down count wraps at once and stops
        push_item(FUNC_WRITE,  REG_CR,    16'h0019);
        repeat (2) push_item(FUNC_TICK, REG_CR, 16'h0000);
        push_item(FUNC_WRITE,  REG_PSC,   16'hffff);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady_flow = (n >= 500 && n < 800);
            pick = $urandom_range(0, 99);
            idx  = 5'($urandom_range(0, 19));
            data = 16'($urandom);
            if (pick < 55)
                func = FUNC_TICK;
            else if (pick < 85)
            begin
                func = FUNC_WRITE;
                if ($urandom_range(0, 99) < 85)
                    idx = mapped_regs[4'($urandom_range(0, 13))];
                // keep the timer running with short periods most of the time
                case (idx)
                    REG_CR:
                    begin
                        if ($urandom_range(0, 99) < 85)
                            data[CTL_EN_BIT] = 1'b1;
                        if ($urandom_range(0, 3) != 0)
                            data[CTL_OPM_BIT] = 1'b0;
                    end
                    REG_PSC:
                        if ($urandom_range(0, 19) != 0)
                            data = 16'($urandom_range(0, 3));
                    REG_EGR:
                        if ($urandom_range(0, 2) != 0)
                            data[0] = 1'b0;
                    REG_ARR, REG_CNT, REG_CCR1, REG_CCR2, REG_CCR3, REG_CCR4:
                        if ($urandom_range(0, 9) != 0)
                            data = 16'($urandom_range(0, 24));
                    default: ;
                endcase
            end
            else if (pick < 97)
                func = FUNC_READ;
            else
                func = FUNC_UNUSED;
            push_item(func, idx, data);
        end
        s_tvalid <= 1'b0;
        // the last transfer is noted by the bus watcher at this edge
        @(posedge clk);

        while (shadow.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (shadow.pending_results.size() != 0)
            shadow.report_mismatch("results still pending at the end");

        $display("items: %0d ticks, %0d writes, %0d reads, %0d with unused func",
                 shadow.ticks, shadow.writes, shadow.reads, shadow.others);
        $display("counter updates predicted: %0d, mismatches: %0d",
                 shadow.updates, shadow.mismatches);
        if (shadow.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
